@@ sv/epmc_pkg.sv @@
`timescale 1ns / 1ps

package epmc_pkg;

    // Default width of the position and goal counters
    localparam int POSITION_BITS_DEF = 16;

    // Configuration port shape
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Field widths
    localparam int SPAN_BITS       = 17;
    localparam int EDGE_TIMER_BITS = 12;
    localparam int RPT_TIMER_BITS  = 11;
    localparam int PCT_BITS        = 7;

    localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

    // Operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;

    // Reported drive state codes
    localparam logic [1:0] RS_DOWN = 2'd0;
    localparam logic [1:0] RS_UP   = 2'd1;
    localparam logic [1:0] RS_STOP = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_POS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_POS    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EDGE_WIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SENSOR_OFF = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPORT_INT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND   = 3'd6;

    typedef struct packed {
        logic [1:0]         operation;
        logic [11:0]        sensor_sample;
        logic [6:0]         target_percent;
        logic signed [15:0] load_current;
        logic signed [15:0] load_target;
    } t_in;

    typedef struct packed {
        logic               motor_a;
        logic               motor_b;
        logic               sensor_enable;
        logic               report_valid;
        logic [6:0]         report_percent;
        logic [1:0]         report_state;
        logic               accepted;
        logic signed [15:0] current_position;
        logic signed [15:0] target_position;
        logic               persist;
    } t_out;

    typedef struct packed {
        logic signed [15:0] min_position;
        logic signed [15:0] max_position;
        logic [11:0]        sensor_threshold;
        logic [11:0]        edge_window_ms;
        logic [11:0]        sensor_off_ms;
        logic [10:0]        report_interval_ms;
        logic [7:0]         deadband;
    } t_cfg;

endpackage

@@ sv/epmc_cfg.sv @@
`timescale 1ns / 1ps

module epmc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [epmc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [epmc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output epmc_pkg::t_cfg                      o_cfg
);
    import epmc_pkg::*;

    t_cfg r_cfg;

    // Ready when out of reset; the user changes configuration only while idle, unenforced
    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    // Update the addressed register on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_position       <= 16'sd0;
            r_cfg.max_position       <= 16'sd100;
            r_cfg.sensor_threshold   <= 12'd100;
            r_cfg.edge_window_ms     <= 12'd1000;
            r_cfg.sensor_off_ms      <= 12'd2000;
            r_cfg.report_interval_ms <= 11'd1000;
            r_cfg.deadband           <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_POS:    r_cfg.min_position       <= $signed(i_cfg_data);
                CFG_MAX_POS:    r_cfg.max_position       <= $signed(i_cfg_data);
                CFG_THRESHOLD:  r_cfg.sensor_threshold   <= i_cfg_data[11:0];
                CFG_EDGE_WIN:   r_cfg.edge_window_ms     <= i_cfg_data[11:0];
                CFG_SENSOR_OFF: r_cfg.sensor_off_ms      <= i_cfg_data[11:0];
                CFG_REPORT_INT: r_cfg.report_interval_ms <= i_cfg_data[10:0];
                CFG_DEADBAND:   r_cfg.deadband           <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ sv/epmc_div.sv @@
`timescale 1ns / 1ps

module epmc_div #(
    parameter int N_BITS = 26,
    parameter int D_BITS = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_BITS-1:0] i_dividend,
    input  logic [D_BITS-1:0] i_divisor,
    output logic              o_done,
    output logic [N_BITS-1:0] o_quotient
);
    localparam int CNT_BITS = $clog2(N_BITS + 1);

    logic [N_BITS-1:0]   r_quo;
    logic [D_BITS-1:0]   r_rem;
    logic [D_BITS-1:0]   r_div;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [D_BITS:0]     w_trial;
    logic [D_BITS:0]     w_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_trial = {r_rem, r_quo[N_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Flag the cycle after the last quotient bit
            r_done <= r_busy && !i_start && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CNT_BITS'(N_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[D_BITS]) begin
                    r_rem <= w_diff[D_BITS-1:0];
                    r_quo <= {r_quo[N_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[D_BITS-1:0];
                    r_quo <= {r_quo[N_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

@@ sv/encoder_position_motor_controller.sv @@
`timescale 1ns / 1ps
// Ticks, target requests and loads share one restoring divider that yields one quotient
// bit per cycle. One item is handled at a time: the input stalls until the previous
// result is in the output register. Reset (synchronous, active low) restores registers,
// clears both counts, stops the motor, saturates timers.
module encoder_position_motor_controller #(
    parameter int POSITION_BITS = epmc_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  epmc_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output epmc_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [epmc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [epmc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import epmc_pkg::*;

    localparam int PB    = POSITION_BITS;
    localparam int WB    = (PB > 16) ? PB : 16;
    localparam int XW    = WB + 1;
    localparam int NUMW  = XW + 8;
    localparam int NW    = NUMW + 1;
    localparam int ERR_W = PB + 1;

    localparam int COUNT_HALF = 100;
    localparam int COUNT_DIV  = 200;

    localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};
    localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] POS_ONE = {{(PB-1){1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_EDGE, S_ERR2, S_PX, S_PN, S_PDIV, S_WAIT,
        S_PFIN, S_C1, S_C2, S_C3, S_CFIN, S_CDEC, S_LOAD, S_OUT
    } t_state;

    function automatic logic signed [NUMW-1:0] times100(input logic signed [NUMW-1:0] v);
        return (v <<< 6) + (v <<< 5) + (v <<< 2);
    endfunction

    t_cfg w_cfg;

    t_state                      r_state;
    t_in                         r_in;
    logic signed [PB-1:0]        r_pos;
    logic signed [PB-1:0]        r_goal;
    logic signed [PB-1:0]        r_ng;
    logic                        r_moving;
    logic                        r_level;
    logic                        r_down;
    logic                        r_sensor_on;
    logic                        r_line_a;
    logic                        r_line_b;
    logic [EDGE_TIMER_BITS-1:0]  r_ms_edge;
    logic [RPT_TIMER_BITS-1:0]   r_ms_rep;
    logic [PCT_BITS-1:0]         r_last;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [XW-1:0]        r_x;
    logic signed [SPAN_BITS-1:0] r_span;
    logic signed [NUMW-1:0]      r_num;
    logic                        r_pzero;
    logic                        r_rep;
    logic                        r_acc;
    logic                        r_persist;
    t_out                        r_out;
    logic                        r_out_valid;

    logic                        n_moving;
    logic                        n_level;
    logic                        n_down;
    logic                        n_sensor_on;
    logic [EDGE_TIMER_BITS-1:0]  n_ms_edge;
    logic [RPT_TIMER_BITS-1:0]   n_ms_rep;
    logic signed [PB-1:0]        n_pos;
    logic                        n_persist;

    logic signed [ERR_W-1:0]     w_db;
    logic                        w_above;
    logic                        w_below;
    logic                        w_far;
    logic                        w_level;
    logic signed [PB-1:0]        w_src;
    logic [PCT_BITS-1:0]         w_pct_req;
    logic [SPAN_BITS-1:0]        w_abs_span;
    logic [NUMW-1:0]             w_abs_num;
    logic                        w_pskip;
    logic                        w_div_start;
    logic [NW-1:0]               w_div_n;
    logic [SPAN_BITS-1:0]        w_div_d;
    logic                        w_div_done;
    logic [NW-1:0]               w_quo;
    logic [PCT_BITS-1:0]         w_pct;
    logic signed [NW:0]          w_cval;
    logic signed [PB-1:0]        w_ng;
    logic signed [XW-1:0]        w_lc;
    logic signed [XW-1:0]        w_lt;
    logic signed [PB-1:0]        w_lc_sat;
    logic signed [PB-1:0]        w_lt_sat;
    logic signed [WB-1:0]        w_pos_ext;
    logic signed [WB-1:0]        w_goal_ext;
    logic [1:0]                  w_rstate;

    epmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    epmc_div #(
        .N_BITS (NW),
        .D_BITS (SPAN_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Compare the registered error goal - position against the deadband
    assign w_db    = $signed({{(ERR_W-8){1'b0}}, w_cfg.deadband});
    assign w_above = r_err > w_db;
    assign w_below = r_err < -w_db;
    assign w_far   = w_above || w_below;
    assign w_level = r_in.sensor_sample > w_cfg.sensor_threshold;

    // Tick update: timers, start/stop, sensor power, edge counting
    always_comb begin
        n_ms_edge   = (r_ms_edge != '1) ? r_ms_edge + EDGE_TIMER_BITS'(1) : r_ms_edge;
        n_ms_rep    = (r_ms_rep != '1) ? r_ms_rep + RPT_TIMER_BITS'(1) : r_ms_rep;
        n_moving    = r_moving;
        n_sensor_on = r_sensor_on;
        n_level     = r_level;
        n_down      = r_down;
        n_pos       = r_pos;
        n_persist   = 1'b0;
        if (!r_moving && w_far) begin
            n_moving    = 1'b1;
            n_sensor_on = 1'b1;
            n_level     = w_level;
            n_ms_edge   = '0;
            n_down      = !(r_err > $signed(ERR_W'(0)));
        end else if (r_moving && !w_far) begin
            n_moving = 1'b0;
        end
        if (!n_moving && n_ms_edge > w_cfg.sensor_off_ms) begin
            n_sensor_on = 1'b0;
        end
        if (w_level != n_level && n_ms_edge < w_cfg.edge_window_ms) begin
            if (n_down) begin
                if (r_pos != POS_MIN) n_pos = r_pos - POS_ONE;
            end else begin
                if (r_pos != POS_MAX) n_pos = r_pos + POS_ONE;
            end
            n_level   = w_level;
            n_ms_edge = '0;
            n_persist = 1'b1;
        end
    end

    // Percent source: the goal while arrived, else and for a load the position
    assign w_src     = (r_in.operation == OP_LOAD || w_far) ? r_pos : r_goal;
    assign w_pct_req = (r_in.target_percent > PCT_FULL) ? PCT_FULL : r_in.target_percent;

    // Divider operands: rounded quotient as (2n + d) / 2d
    always_comb begin
        w_abs_span = r_span[SPAN_BITS-1] ? SPAN_BITS'(-r_span) : SPAN_BITS'(r_span);
        w_abs_num  = r_num[NUMW-1] ? NUMW'(-r_num) : NUMW'(r_num);
        if (r_in.operation == OP_TARGET) begin
            w_div_n = {w_abs_num, 1'b0} + NW'(COUNT_HALF);
            w_div_d = SPAN_BITS'(COUNT_DIV);
        end else begin
            w_div_n = {r_num, 1'b0} + NW'(w_abs_span);
            w_div_d = {w_abs_span[SPAN_BITS-2:0], 1'b0};
        end
    end

    assign w_pskip     = r_pzero || r_num[NUMW-1] || (r_num == '0);
    assign w_div_start = (r_state == S_PDIV && !w_pskip) || (r_state == S_C3);

    // Clamp the percent quotient
    assign w_pct = r_pzero ? '0 : ((w_quo > NW'(PCT_FULL)) ? PCT_FULL : w_quo[PCT_BITS-1:0]);

    // Signed count from the quotient, saturated to the counter range
    assign w_cval = r_num[NUMW-1] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_ng   = ((&w_cval[NW:PB-1]) || !(|w_cval[NW:PB-1])) ? w_cval[PB-1:0]
                  : (w_cval[NW] ? POS_MIN : POS_MAX);

    // Saturate loaded counts
    assign w_lc     = XW'($signed(r_in.load_current));
    assign w_lt     = XW'($signed(r_in.load_target));
    assign w_lc_sat = ((&w_lc[XW-1:PB-1]) || !(|w_lc[XW-1:PB-1])) ? w_lc[PB-1:0]
                    : (w_lc[XW-1] ? POS_MIN : POS_MAX);
    assign w_lt_sat = ((&w_lt[XW-1:PB-1]) || !(|w_lt[XW-1:PB-1])) ? w_lt[PB-1:0]
                    : (w_lt[XW-1] ? POS_MIN : POS_MAX);

    assign w_pos_ext  = WB'(r_pos);
    assign w_goal_ext = WB'(r_goal);
    assign w_rstate   = r_line_a ? RS_UP : (r_line_b ? RS_DOWN : RS_STOP);

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_goal      <= '0;
            r_moving    <= 1'b0;
            r_level     <= 1'b0;
            r_down      <= 1'b0;
            r_sensor_on <= 1'b0;
            r_line_a    <= 1'b0;
            r_line_b    <= 1'b0;
            r_ms_edge   <= '1;
            r_ms_rep    <= '1;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid when a result is loaded, drop it once transferred
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in      <= i_in_data;
                        r_rep     <= 1'b0;
                        r_acc     <= 1'b0;
                        r_persist <= 1'b0;
                        r_pzero   <= 1'b0;
                        case (i_in_data.operation)
                            OP_TICK:   r_state <= S_ERR;
                            OP_TARGET: r_state <= S_ERR;
                            OP_LOAD:   r_state <= S_LOAD;
                            default:   r_state <= S_OUT;
                        endcase
                    end
                end
                S_ERR: begin
                    r_err   <= ERR_W'(r_goal) - ERR_W'(r_pos);
                    r_state <= (r_in.operation == OP_TICK) ? S_EDGE : S_C1;
                end
                S_EDGE: begin
                    r_ms_edge   <= n_ms_edge;
                    r_ms_rep    <= n_ms_rep;
                    r_moving    <= n_moving;
                    r_sensor_on <= n_sensor_on;
                    r_level     <= n_level;
                    r_down      <= n_down;
                    r_pos       <= n_pos;
                    r_persist   <= n_persist;
                    r_state     <= S_ERR2;
                end
                S_ERR2: begin
                    r_err   <= ERR_W'(r_goal) - ERR_W'(r_pos);
                    r_state <= S_PX;
                end
                S_PX: begin
                    if (r_in.operation == OP_TICK) begin
                        r_line_a <= w_above;
                        r_line_b <= w_below;
                    end
                    r_x     <= XW'(w_src) - XW'(w_cfg.min_position);
                    r_span  <= SPAN_BITS'(w_cfg.max_position) - SPAN_BITS'(w_cfg.min_position);
                    r_state <= S_PN;
                end
                S_PN: begin
                    // Flip the sign for a reversed span
                    if (r_span[SPAN_BITS-1]) r_num <= -times100(NUMW'(r_x));
                    else r_num <= times100(NUMW'(r_x));
                    r_pzero <= (r_span == '0);
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    if (w_pskip) begin
                        r_pzero <= 1'b1;
                        r_state <= S_PFIN;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        r_state <= (r_in.operation == OP_TARGET) ? S_CFIN : S_PFIN;
                    end
                end
                S_PFIN: begin
                    if (r_in.operation == OP_LOAD) begin
                        r_last <= w_pct;
                        r_rep  <= 1'b1;
                    end else if (r_ms_rep > w_cfg.report_interval_ms && r_last != w_pct) begin
                        r_last   <= w_pct;
                        r_ms_rep <= '0;
                        r_rep    <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_C1: begin
                    r_span  <= SPAN_BITS'(w_cfg.max_position) - SPAN_BITS'(w_cfg.min_position);
                    r_num   <= times100(NUMW'(w_cfg.min_position));
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_num   <= r_num + NUMW'(r_span) * $signed(NUMW'(w_pct_req));
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_state <= S_WAIT;
                end
                S_CFIN: begin
                    r_ng    <= w_ng;
                    r_state <= S_CDEC;
                end
                S_CDEC: begin
                    // Drop a request that would reverse a running motor; stop at the position
                    if (w_far && ((r_err > $signed(ERR_W'(0))) != (r_ng > r_pos))) begin
                        r_goal <= r_pos;
                        r_acc  <= 1'b0;
                    end else begin
                        r_goal <= r_ng;
                        r_acc  <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_LOAD: begin
                    r_pos     <= w_lc_sat;
                    r_goal    <= w_lt_sat;
                    r_persist <= 1'b1;
                    r_state   <= S_PX;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.motor_a          <= r_line_a;
                        r_out.motor_b          <= r_line_b;
                        r_out.sensor_enable    <= r_sensor_on;
                        r_out.report_valid     <= r_rep;
                        r_out.report_percent   <= r_last;
                        r_out.report_state     <= w_rstate;
                        r_out.accepted         <= r_acc;
                        r_out.current_position <= w_pos_ext[15:0];
                        r_out.target_position  <= w_goal_ext[15:0];
                        r_out.persist          <= r_persist;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/encoder_position_motor_controller_test.sv @@
`timescale 1ns / 1ps

module encoder_position_motor_controller_test;
    import epmc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 225;
    localparam int HOLD_CYCLES   = 400;
    localparam int EDGE_SAT      = 4095;
    localparam int REPORT_SAT    = 2047;
    localparam longint COUNT_HI  = (longint'(1) <<< (POSITION_BITS_DEF - 1)) - 1;
    localparam longint COUNT_LO  = -(longint'(1) <<< (POSITION_BITS_DEF - 1));

    // Spare operation code; the block changes no state but still returns a frame
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Controller state mirror: predicts one output frame per accepted transfer
    class position_tracker;
        longint min_pos, max_pos, threshold, edge_window, sensor_off, report_gap, deadband;
        longint pos, goal;
        bit     moving, level_q, travel_down, sensor_on, line_a, line_b;
        int     since_edge, since_report, last_pct;
        t_out   awaited[$];
        int     errors;

        function new();
            errors = 0;
            min_pos = 0;
            max_pos = 100;
            threshold = 100;
            edge_window = 1000;
            sensor_off = 2000;
            report_gap = 1000;
            deadband = 1;
            pos = 0;
            goal = 0;
            moving = 0;
            level_q = 0;
            travel_down = 0;
            sensor_on = 0;
            line_a = 0;
            line_b = 0;
            since_edge = EDGE_SAT;
            since_report = REPORT_SAT;
            last_pct = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_MIN_POS:    min_pos = longint'($signed(val));
                CFG_MAX_POS:    max_pos = longint'($signed(val));
                CFG_THRESHOLD:  threshold = longint'(val[11:0]);
                CFG_EDGE_WIN:   edge_window = longint'(val[11:0]);
                CFG_SENSOR_OFF: sensor_off = longint'(val[11:0]);
                CFG_REPORT_INT: report_gap = longint'(val[10:0]);
                CFG_DEADBAND:   deadband = longint'(val[7:0]);
                default: ;
            endcase
        endfunction

        function longint clamp_count(longint v);
            if (v > COUNT_HI) return COUNT_HI;
            if (v < COUNT_LO) return COUNT_LO;
            return v;
        endfunction

        // Round half away from zero
        function longint div_round(longint num, longint den);
            if (num >= 0) return (2 * num + den) / (2 * den);
            return -((2 * (-num) + den) / (2 * den));
        endfunction

        function int to_percent(longint p);
            longint span, num, q;
            span = max_pos - min_pos;
            num = (p - min_pos) * 100;
            if (span == 0) return 0;
            if (span < 0) begin
                span = -span;
                num = -num;
            end
            q = div_round(num, span);
            if (q < 0) return 0;
            if (q > 100) return 100;
            return int'(q);
        endfunction

        function longint to_count(int pct);
            longint r, num;
            r = (pct > 100) ? 100 : pct;
            num = min_pos * 100 + (max_pos - min_pos) * r;
            return clamp_count(div_round(num, 100));
        endfunction

        function longint distance();
            return (pos > goal) ? pos - goal : goal - pos;
        endfunction

        function t_out control_step(t_in it);
            t_out   o;
            bit     lvl;
            longint ng;
            int     pct;
            o = '0;
            case (it.operation)
                OP_TICK: begin
                    lvl = longint'(it.sensor_sample) > threshold;
                    if (since_edge < EDGE_SAT) since_edge++;
                    if (since_report < REPORT_SAT) since_report++;
                    // Start or stop around the deadband
                    if (!moving && distance() > deadband) begin
                        moving = 1;
                        sensor_on = 1;
                        level_q = lvl;
                        since_edge = 0;
                        travel_down = !(goal > pos);
                    end else if (moving && distance() <= deadband) begin
                        moving = 0;
                    end
                    if (!moving && since_edge > sensor_off) sensor_on = 0;
                    // Count a level change inside the edge window
                    if (lvl != level_q && since_edge < edge_window) begin
                        pos = clamp_count(pos + (travel_down ? -1 : 1));
                        level_q = lvl;
                        since_edge = 0;
                        o.persist = 1;
                    end
                    line_a = goal > pos + deadband;
                    line_b = !line_a && goal < pos - deadband;
                    pct = (distance() <= deadband) ? to_percent(goal) : to_percent(pos);
                    if (since_report > report_gap && last_pct != pct) begin
                        last_pct = pct;
                        since_report = 0;
                        o.report_valid = 1;
                    end
                end
                OP_TARGET: begin
                    ng = to_count(int'(it.target_percent));
                    o.accepted = 1;
                    // Stop instead of reversing a running motor
                    if (distance() > deadband && ((goal > pos) != (ng > pos))) begin
                        goal = pos;
                        o.accepted = 0;
                    end else begin
                        goal = ng;
                    end
                end
                OP_LOAD: begin
                    pos = clamp_count(longint'(it.load_current));
                    goal = clamp_count(longint'(it.load_target));
                    o.persist = 1;
                    last_pct = to_percent(pos);
                    o.report_valid = 1;
                end
                default: ;
            endcase
            o.motor_a = line_a;
            o.motor_b = line_b;
            o.sensor_enable = sensor_on;
            o.report_percent = last_pct[6:0];
            o.report_state = line_a ? RS_UP : (line_b ? RS_DOWN : RS_STOP);
            o.current_position = pos[15:0];
            o.target_position = goal[15:0];
            return o;
        endfunction

        function void note_input(t_in it);
            awaited.push_back(control_step(it));
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: output expected none actual %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("motor_a", want.motor_a, got.motor_a);
            compare_field("motor_b", want.motor_b, got.motor_b);
            compare_field("sensor_enable", want.sensor_enable, got.sensor_enable);
            compare_field("report_valid", want.report_valid, got.report_valid);
            compare_field("report_percent", want.report_percent, got.report_percent);
            compare_field("report_state", want.report_state, got.report_state);
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("current_position", want.current_position, got.current_position);
            compare_field("target_position", want.target_position, got.target_position);
            compare_field("persist", want.persist, got.persist);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    t_in                       i_in_data;
    logic                      o_out_valid;
    logic                      i_out_stall;
    t_out                      o_out_data;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    position_tracker tracker;
    int send_idle;
    int stall_pct;
    int hold_request;
    int sent;
    int cycle_count;

    encoder_position_motor_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Offer one transfer, idling first at the sender rate
    task automatic send_item(input t_in it);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_input(it);
        if (it.operation != OP_SPARE) sent++;
    endtask

    // Leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_register(idx, val);
    endtask

    task automatic apply_settings(input int mn, input int mx, input int thr, input int win,
                                  input int off, input int rpt, input int db);
        write_reg(CFG_MIN_POS, mn[15:0]);
        write_reg(CFG_MAX_POS, mx[15:0]);
        write_reg(CFG_THRESHOLD, thr[15:0]);
        write_reg(CFG_EDGE_WIN, win[15:0]);
        write_reg(CFG_SENSOR_OFF, off[15:0]);
        write_reg(CFG_REPORT_INT, rpt[15:0]);
        write_reg(CFG_DEADBAND, db[15:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every frame, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in make_item(input logic [1:0] op, input logic [11:0] sample,
                                      input logic [6:0] pct, input logic [15:0] cur,
                                      input logic [15:0] tgt);
        t_in it;
        it.operation = op;
        it.sensor_sample = sample;
        it.target_percent = pct;
        it.load_current = cur;
        it.load_target = tgt;
        return it;
    endfunction

    function automatic t_in noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in)-1:0];
    endfunction

    function automatic logic [6:0] pick_percent();
        if ($urandom_range(9) == 0) return 7'($urandom_range(127, 101));
        return 7'($urandom_range(100));
    endfunction

    // Mostly a count inside the configured span, sometimes any count
    function automatic logic [15:0] pick_count();
        longint lo, hi;
        lo = (tracker.min_pos < tracker.max_pos) ? tracker.min_pos : tracker.max_pos;
        hi = (tracker.min_pos < tracker.max_pos) ? tracker.max_pos : tracker.min_pos;
        if ($urandom_range(7) == 0) return 16'($urandom);
        return 16'(lo + longint'($urandom_range(int'(hi - lo))));
    endfunction

    function automatic logic [11:0] sample_at(input bit lvl);
        int thr;
        thr = int'(tracker.threshold);
        if (lvl && thr < 4095) return 12'($urandom_range(4095, thr + 1));
        if (lvl) return 12'hFFF;
        return 12'($urandom_range(thr, 0));
    endfunction

    // A request or random item, then mostly ticks with a toggling sensor level
    task automatic run_episode();
        t_in it;
        int  kind, n, per, k;
        bit  lvl;
        kind = $urandom_range(9);
        it = noise_item();
        if (kind < 2) begin
            it.operation = OP_LOAD;
            it.load_current = pick_count();
            it.load_target = pick_count();
        end else if (kind < 7) begin
            it.operation = OP_TARGET;
            it.target_percent = pick_percent();
        end
        send_item(it);
        n = $urandom_range(40, 4);
        per = $urandom_range(5, 1);
        lvl = 1'($urandom_range(1));
        for (k = 0; k < n; k++) begin
            it = noise_item();
            if ($urandom_range(15) == 0) begin
                it.operation = OP_TARGET;
                it.target_percent = pick_percent();
            end else begin
                if (k % per == 0) lvl = !lvl;
                it.operation = OP_TICK;
                it.sensor_sample = sample_at(lvl);
            end
            send_item(it);
        end
    endtask

    task automatic run_phase(input int idle_in, input int idle_out, input int hold);
        send_idle = idle_in;
        stall_pct = idle_out;
        hold_request = hold;
        sent = 0;
        while (sent < PHASE_ITEMS) run_episode();
        settle();
    endtask

    // Output side: check accepted frames, stall at random or hold off
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                tracker.check_result(o_out_data);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int mn, mx;
        tracker = new();
        send_idle = 0;
        stall_pct = 0;
        hold_request = 0;
        sent = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, extremes, reversal, saturation, idle edges
        send_item(make_item(OP_TICK, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_SPARE, 12'hFFF, 7'h7F, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_LOAD, 12'h000, 7'd0, 16'h7FFF, 16'h8000));
        send_item(make_item(OP_LOAD, 12'hFFF, 7'h7F, 16'h8000, 16'h7FFF));
        send_item(make_item(OP_LOAD, 12'h000, 7'd0, 16'd50, 16'd50));
        send_item(make_item(OP_TARGET, 12'h000, 7'd100, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'hFFF, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TARGET, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TARGET, 12'h000, 7'd127, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'hFFF, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_LOAD, 12'h000, 7'd0, 16'h7FFE, 16'h7FFF));
        send_item(make_item(OP_TICK, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'hFFF, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TARGET, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'd100, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'd101, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_TARGET, 12'h000, 7'd50, 16'h0000, 16'h0000));
        send_item(make_item(OP_TICK, 12'h000, 7'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_LOAD, 12'h000, 7'd0, 16'h0000, 16'h0000));
        settle();

        // Full span, lowest nonzero timers, zero deadband
        apply_settings(-32768, 32767, 0, 1, 1, 1, 0);
        run_phase(0, 0, 0);
        apply_settings(-100, 300, 2048, 8, 16, 3, 2);
        run_phase(74, 0, 0);
        // Inverted full span, top threshold and deadband, near-top timers
        apply_settings(32767, -32768, 4095, 4094, 4094, 2046, 255);
        run_phase(0, 74, 0);
        // Zero span
        apply_settings(500, 500, 1000, 30, 5, 1, 0);
        run_phase(7, 7, 0);
        // Inverted span; hold off the output so the block backs up
        apply_settings(400, -400, 3000, 12, 50, 2, 1);
        run_phase(0, 0, HOLD_CYCLES);
        mn = int'($urandom_range(2000)) - 1000;
        mx = mn + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(600, 20));
        apply_settings(mn, mx, int'($urandom_range(4000, 50)), int'($urandom_range(40, 2)),
                       int'($urandom_range(80, 1)), int'($urandom_range(10, 1)),
                       int'($urandom_range(4)));
        run_phase(74, 0, 0);

        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
